### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; defined empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_HOLDS(label, clk, rst_n, !(cond), msg)

`else

`define ASSERT_HOLDS(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

### rtl/core/bfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfb_pkg
// Shared types and constants of the burst byte ring FIFO.
// ----------------------------------------------------------------------------
package bfb_pkg;

    localparam int LEN_W  = 7;
    localparam int DATA_W = 8;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_PEEK  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_UNDER = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_READ
    } ctrl_state_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic              has_data;
        status_t           status;
        logic              last;
    } rsp_word_t;

endpackage

### rtl/core/bfb_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfb_req_if
// Request channel: mode, burst length and data byte with valid/ready.
// ----------------------------------------------------------------------------
interface bfb_req_if
    import bfb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  burst_length;
    logic [DATA_W-1:0] data_in;

    modport source (output valid, output mode, output burst_length, output data_in,
                    input ready);
    modport sink   (input valid, input mode, input burst_length, input data_in,
                    output ready);
endinterface

### rtl/core/bfb_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfb_rsp_if
// Response channel: data byte, flags and status with valid/ready.
// ----------------------------------------------------------------------------
interface bfb_rsp_if
    import bfb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_out;
    logic              has_data;
    logic [STAT_W-1:0] status;
    logic              last;

    modport source (output valid, output data_out, output has_data, output status,
                    output last, input ready);
    modport sink   (input valid, input data_out, input has_data, input status,
                    input last, output ready);
endinterface

### rtl/core/bfb_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfb_mem
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfb_mem
    import bfb_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [DATA_W-1:0]                    wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [DATA_W-1:0]                    rdata
);

    logic [DATA_W-1:0] store_mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/bfb_oq.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// bfb_oq
// Four-word response queue decoupling the control from the sink.
// ----------------------------------------------------------------------------
module bfb_oq
    import bfb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rsp_word_t        word,
    output logic [QCW-1:0]   count,
    bfb_rsp_if.source        rsp
);

    rsp_word_t          entry_reg [QDEPTH];
    logic [QAW-1:0]     wptr_reg;
    logic [QAW-1:0]     wptr_next;
    logic [QAW-1:0]     rptr_reg;
    logic [QAW-1:0]     rptr_next;
    logic [QCW-1:0]     count_reg;
    logic [QCW-1:0]     count_next;
    logic               pop;
    rsp_word_t          head;

    assign pop  = rsp.valid && rsp.ready;
    assign head = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? wptr_reg + QAW'(1) : wptr_reg;
        rptr_next  = pop ? rptr_reg + QAW'(1) : rptr_reg;
        count_next = count_reg + QCW'(push) - QCW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= word;
        end
    end

    assign count        = count_reg;
    assign rsp.valid    = (count_reg != '0);
    assign rsp.data_out = head.data_out;
    assign rsp.has_data = head.has_data;
    assign rsp.status   = head.status;
    assign rsp.last     = head.last;

    `ASSERT_NEVER(a_oq_overflow, clk, rst_n, push && !pop && (count_reg == QCW'(QDEPTH)), "response queue overflow")
    `ASSERT_HOLDS(a_oq_drain, clk, rst_n, (pop && !push) |=> (count_reg == $past(count_reg) - QCW'(1)), "queue count did not drop on pop")
    `ASSERT_HOLDS(a_oq_fill, clk, rst_n, push |=> rsp.valid, "pushed word not visible")

endmodule

### rtl/core/bfb_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// bfb_ctrl
// Pointer and count control, push run sequencing and read burst issue.
// ----------------------------------------------------------------------------
module bfb_ctrl
    import bfb_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 64
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    bfb_req_if.sink                              req,
    input  logic [QCW-1:0]                       q_count,
    output logic                                 q_push,
    output rsp_word_t                            q_word,
    output logic                                 mem_we,
    output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] mem_waddr,
    output logic [DATA_W-1:0]                    mem_wdata,
    output logic                                 mem_re,
    output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] mem_raddr,
    input  logic [DATA_W-1:0]                    mem_rdata
);

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW  = $clog2(DEPTH + 1);
    localparam int CW  = ((FW > LEN_W) ? FW : LEN_W) + 1;
    localparam int SW  = ((AW > LEN_W) ? AW : LEN_W) + 2;
    localparam int QSW = QCW + 1;

    ctrl_state_t        state_reg;
    ctrl_state_t        state_next;
    logic [AW-1:0]      rp_reg;
    logic [AW-1:0]      rp_next;
    logic [FW-1:0]      fill_reg;
    logic [FW-1:0]      fill_next;
    logic [AW-1:0]      wp_reg;
    logic [AW-1:0]      wp_next;
    logic [LEN_W-1:0]   remain_reg;
    logic [LEN_W-1:0]   remain_next;
    logic [LEN_W-1:0]   total_reg;
    logic [LEN_W-1:0]   total_next;
    logic               ok_reg;
    logic               ok_next;
    logic [AW-1:0]      raddr_reg;
    logic [AW-1:0]      raddr_next;
    logic [LEN_W-1:0]   rleft_reg;
    logic [LEN_W-1:0]   rleft_next;
    logic               pend_reg;
    logic               pend_next;
    logic               pend_last_reg;
    logic               pend_last_next;

    logic [LEN_W-1:0]   len_c;
    logic [CW-1:0]      free_c;
    logic [SW-1:0]      wsum;
    logic [AW-1:0]      wpos;
    logic [SW-1:0]      psum;
    logic [AW-1:0]      ppos;
    logic [AW-1:0]      wp_inc;
    logic [AW-1:0]      ra_inc;
    logic               room;
    logic               ready_c;
    logic               acc;
    logic               imm_push;
    status_t            imm_status;

    always_comb
    begin
        len_c  = (req.burst_length > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST)
                                                         : req.burst_length;
        free_c = CW'(DEPTH) - CW'(fill_reg);
        wsum   = SW'(rp_reg) + SW'(fill_reg);
        wpos   = (wsum >= SW'(DEPTH)) ? AW'(wsum - SW'(DEPTH)) : AW'(wsum);
        psum   = SW'(rp_reg) + SW'(len_c);
        ppos   = (psum >= SW'(DEPTH)) ? AW'(psum - SW'(DEPTH)) : AW'(psum);
        wp_inc = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
        ra_inc = (raddr_reg == AW'(DEPTH - 1)) ? '0 : raddr_reg + AW'(1);
        room   = (QSW'(q_count) + QSW'(pend_reg)) < QSW'(QDEPTH);

        ready_c = (state_reg != S_READ) && !pend_reg && (q_count < QCW'(QDEPTH));
        acc     = req.valid && ready_c;

        state_next     = state_reg;
        rp_next        = rp_reg;
        fill_next      = fill_reg;
        wp_next        = wp_reg;
        remain_next    = remain_reg;
        total_next     = total_reg;
        ok_next        = ok_reg;
        raddr_next     = raddr_reg;
        rleft_next     = rleft_reg;
        pend_next      = 1'b0;
        pend_last_next = pend_last_reg;
        imm_push       = 1'b0;
        imm_status     = ST_OK;
        mem_we         = 1'b0;
        mem_waddr      = wp_reg;
        mem_wdata      = req.data_in;
        mem_re         = 1'b0;
        mem_raddr      = raddr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    unique case (req.mode)
                        MODE_PUSH:
                        begin
                            if (len_c == '0)
                            begin
                                imm_push = 1'b1;
                            end
                            else
                            begin
                                state_next  = S_PUSH;
                                total_next  = len_c;
                                remain_next = len_c;
                                ok_next     = (CW'(len_c) <= free_c);
                                wp_next     = wpos;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            fill_next = '0;
                            rp_next   = '0;
                            imm_push  = 1'b1;
                        end
                        MODE_POP, MODE_PEEK:
                        begin
                            if (CW'(len_c) > CW'(fill_reg))
                            begin
                                imm_push   = 1'b1;
                                imm_status = ST_UNDER;
                            end
                            else if (len_c == '0)
                            begin
                                imm_push = 1'b1;
                            end
                            else
                            begin
                                state_next = S_READ;
                                raddr_next = rp_reg;
                                rleft_next = len_c;
                                if (req.mode == MODE_POP)
                                begin
                                    fill_next = fill_reg - FW'(len_c);
                                    rp_next   = ppos;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_PUSH:
            begin
                if (acc)
                begin
                    if (ok_reg)
                    begin
                        mem_we  = 1'b1;
                        wp_next = wp_inc;
                    end
                    remain_next = remain_reg - LEN_W'(1);
                    if (remain_reg == LEN_W'(1))
                    begin
                        imm_push   = 1'b1;
                        imm_status = ok_reg ? ST_OK : ST_FULL;
                        if (ok_reg)
                        begin
                            fill_next = fill_reg + FW'(total_reg);
                        end
                        ok_next    = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            S_READ:
            begin
                if (room)
                begin
                    mem_re         = 1'b1;
                    raddr_next     = ra_inc;
                    rleft_next     = rleft_reg - LEN_W'(1);
                    pend_next      = 1'b1;
                    pend_last_next = (rleft_reg == LEN_W'(1));
                    if (rleft_reg == LEN_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        q_push = imm_push || pend_reg;
        if (pend_reg)
        begin
            q_word.data_out = mem_rdata;
            q_word.has_data = 1'b1;
            q_word.status   = ST_OK;
            q_word.last     = pend_last_reg;
        end
        else
        begin
            q_word.data_out = '0;
            q_word.has_data = 1'b0;
            q_word.status   = imm_status;
            q_word.last     = 1'b1;
        end
    end

    assign req.ready = ready_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rp_reg        <= '0;
            fill_reg      <= '0;
            wp_reg        <= '0;
            remain_reg    <= '0;
            total_reg     <= '0;
            ok_reg        <= 1'b0;
            raddr_reg     <= '0;
            rleft_reg     <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            fill_reg      <= fill_next;
            wp_reg        <= wp_next;
            remain_reg    <= remain_next;
            total_reg     <= total_next;
            ok_reg        <= ok_next;
            raddr_reg     <= raddr_next;
            rleft_reg     <= rleft_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
        end
    end

    `ASSERT_NEVER(a_fill_range, clk, rst_n, fill_reg > FW'(DEPTH), "fill count above depth")
    `ASSERT_HOLDS(a_pend_after_read, clk, rst_n, pend_reg |-> $past(mem_re), "read data without a read")
    `ASSERT_NEVER(a_single_push, clk, rst_n, pend_reg && imm_push, "two responses in one cycle")

endmodule

### rtl/core/byte_ring_fifo_burst.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_burst
// Circular byte FIFO with all-or-nothing burst push, pop, peek and clear.
// ----------------------------------------------------------------------------
// A push header, each push byte, a clear and a pop or peek that answers at
// once (zero length or underflow) each take a single request word. A pop or
// peek of N bytes returns N words at one per cycle while the response queue
// has room, one per read of the single read port of the byte store, and
// holds off the next request until the last read has issued and its data
// has landed. Responses go through a four-word queue, so requests keep
// flowing while the sink stalls, until that queue is full. No clearing pass
// after reset; bytes are only read where a push has written them.
module byte_ring_fifo_burst
    import bfb_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    bfb_req_if.sink     req,
    bfb_rsp_if.source   rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [QCW-1:0]     q_count;
    logic               q_push;
    rsp_word_t          q_word;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [DATA_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [DATA_W-1:0]  mem_rdata;

    bfb_ctrl #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .q_count   (q_count),
        .q_push    (q_push),
        .q_word    (q_word),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bfb_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bfb_oq u_oq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .word  (q_word),
        .count (q_count),
        .rsp   (rsp)
    );

endmodule
